/* rtl/core/assert_macros.svh */
// Assertion macros shared by the normalizer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a condition at every clock edge outside reset.
`define ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Check that a trigger is followed by a condition in the next cycle.
`define ASSERT_NEXT(label, trig, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cond)) else $error(msg);

`endif

/* rtl/core/scs_pkg.sv */
// Types, character codes and helpers for the comment strip normalizer.
package scs_pkg;

  localparam logic FUNC_TEXT = 1'b0;
  localparam logic FUNC_END  = 1'b1;

  localparam logic [7:0] CH_NL    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_STAR  = 8'h2A;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_COMMA = 8'h2C;
  localparam logic [7:0] CH_QUEST = 8'h3F;
  localparam logic [7:0] CH_SEMI  = 8'h3B;

  localparam int MAX_BYTES   = 3;
  localparam int QUEUE_DEPTH = 2;
  localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

  typedef enum logic [2:0] {
    MODE_NORMAL = 3'd0,
    MODE_SLASH  = 3'd1,
    MODE_LINE   = 3'd2,
    MODE_BLOCK  = 3'd3,
    MODE_STAR   = 3'd4
  } mode_t;

  // One queued group of results caused by a single transaction.
  typedef struct packed {
    logic [MAX_BYTES-1:0][7:0] bytes;
    logic [1:0]                last_idx;
    logic                      is_end;
    logic                      bare;
  } entry_t;

  typedef struct packed {
    logic   push;
    entry_t entry;
  } push_t;

  function automatic logic [7:0] map_ws(input logic [7:0] c);
    if (c == CH_NL || c == CH_CR || c == CH_TAB) begin
      return CH_SP;
    end
    return c;
  endfunction

  function automatic logic is_punct(input logic [7:0] c);
    return (c == CH_DOT) || (c == CH_COMMA) || (c == CH_QUEST) || (c == CH_SEMI);
  endfunction

endpackage

/* rtl/core/scs_front.sv */
// Front end: scan state, comment removal and space folding per transaction.
`include "assert_macros.svh"

module scs_front (
  input  logic           clk,
  input  logic           rst,
  input  logic           in_valid,
  output logic           in_ready,
  input  logic           func,
  input  logic [7:0]     ch,
  input  logic           q_full,
  output scs_pkg::push_t wr
);
  import scs_pkg::*;

  mode_t      mode, mode_next;
  logic       space_pending, space_pending_next;
  logic       text_started, text_started_next;
  logic       acc;
  logic       end_acc;
  logic       scan_clear;
  logic [7:0] cm;
  logic       emit_sp, emit_sl, emit_c;
  logic [1:0] n;
  logic [MAX_BYTES-1:0][7:0] bytes;

  assign in_ready   = !q_full;
  assign acc        = in_valid && in_ready;
  assign end_acc    = acc && (func == FUNC_END);
  assign scan_clear = (mode == MODE_NORMAL) && !space_pending && !text_started;
  assign cm         = map_ws(ch);

  always_ff @(posedge clk) begin
    if (rst) begin
      mode          <= MODE_NORMAL;
      space_pending <= 1'b0;
      text_started  <= 1'b0;
    end else begin
      mode          <= mode_next;
      space_pending <= space_pending_next;
      text_started  <= text_started_next;
    end
  end

  // Next state
  always_comb begin
    mode_next          = mode;
    space_pending_next = space_pending;
    text_started_next  = text_started;
    if (acc) begin
      if (func == FUNC_END) begin
        mode_next          = MODE_NORMAL;
        space_pending_next = 1'b0;
        text_started_next  = 1'b0;
      end else begin
        unique case (mode)
          MODE_SLASH: begin
            if (ch == CH_SLASH) begin
              mode_next = MODE_LINE;
            end else if (ch == CH_STAR) begin
              mode_next = MODE_BLOCK;
            end else begin
              mode_next          = MODE_NORMAL;
              text_started_next  = 1'b1;
              space_pending_next = (cm == CH_SP);
            end
          end
          MODE_LINE: begin
            if (ch == CH_NL) begin
              mode_next = MODE_NORMAL;
            end
          end
          MODE_BLOCK: begin
            if (ch == CH_STAR) begin
              mode_next = MODE_STAR;
            end
          end
          MODE_STAR: begin
            if (ch == CH_SLASH) begin
              mode_next = MODE_NORMAL;
            end else if (ch != CH_STAR) begin
              mode_next = MODE_BLOCK;
            end
          end
          default: begin
            mode_next = MODE_NORMAL;
            if (ch == CH_SLASH) begin
              mode_next = MODE_SLASH;
            end else if (cm == CH_SP) begin
              space_pending_next = text_started;
            end else begin
              space_pending_next = 1'b0;
              text_started_next  = 1'b1;
            end
          end
        endcase
      end
    end
  end

  // Outputs: which of space, slash and the byte itself this transaction yields
  always_comb begin
    emit_sp = 1'b0;
    emit_sl = 1'b0;
    emit_c  = 1'b0;
    if (func == FUNC_END) begin
      emit_sl = (mode == MODE_SLASH);
      emit_sp = space_pending;
    end else begin
      unique case (mode) inside
        MODE_SLASH: begin
          if (ch != CH_SLASH && ch != CH_STAR) begin
            emit_sp = space_pending;
            emit_sl = 1'b1;
            emit_c  = (cm != CH_SP);
          end
        end
        MODE_LINE, MODE_BLOCK, MODE_STAR: begin
          emit_c = 1'b0;
        end
        default: begin
          if (ch != CH_SLASH && cm != CH_SP) begin
            emit_sp = space_pending && !is_punct(cm);
            emit_c  = 1'b1;
          end
        end
      endcase
    end
  end

  // Pack the emitted bytes in order
  always_comb begin
    n     = 2'd0;
    bytes = '0;
    if (emit_sp) begin
      bytes[n] = CH_SP;
      n        = n + 2'd1;
    end
    if (emit_sl) begin
      bytes[n] = CH_SLASH;
      n        = n + 2'd1;
    end
    if (emit_c) begin
      bytes[n] = cm;
      n        = n + 2'd1;
    end
  end

  always_comb begin
    wr.entry.bytes    = bytes;
    wr.entry.is_end   = (func == FUNC_END);
    wr.entry.bare     = (func == FUNC_END) && (n == 2'd0);
    wr.entry.last_idx = (n == 2'd0) ? 2'd0 : n - 2'd1;
    wr.push           = acc && ((func == FUNC_END) || (n != 2'd0));
  end

  `ASSERT_NEXT(a_end_resets, end_acc, scan_clear, "end of text left scan state set")
  `ASSERT_ALWAYS(a_pending_needs_start, !space_pending || text_started, "space held before text")

endmodule

/* rtl/core/scs_queue.sv */
// Short result-group queue between the front and back ends.
`include "assert_macros.svh"

module scs_queue (
  input  logic            clk,
  input  logic            rst,
  input  scs_pkg::push_t  wr,
  output logic            full,
  output logic            rd_valid,
  output scs_pkg::entry_t rd_entry,
  input  logic            pop
);
  import scs_pkg::*;

  entry_t           store [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] cnt;
  logic             do_pop;

  assign full     = (cnt == CNT_W'(QUEUE_DEPTH));
  assign rd_valid = (cnt != '0);
  assign rd_entry = store[rd_ptr];
  assign do_pop   = pop && rd_valid;

  always_ff @(posedge clk) begin
    if (wr.push) begin
      store[wr_ptr] <= wr.entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      cnt    <= '0;
    end else begin
      if (wr.push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (wr.push && !do_pop) begin
        cnt <= cnt + 1'b1;
      end else if (do_pop && !wr.push) begin
        cnt <= cnt - 1'b1;
      end
    end
  end

  `ASSERT_ALWAYS(a_no_overflow, !(wr.push && full), "push into full queue")
  `ASSERT_ALWAYS(a_cnt_range, cnt <= CNT_W'(QUEUE_DEPTH), "queue count out of range")

endmodule

/* rtl/core/scs_back.sv */
// Back end: plays out each queued group, one byte per result transaction.
`include "assert_macros.svh"

module scs_back (
  input  logic            clk,
  input  logic            rst,
  input  logic            rd_valid,
  input  scs_pkg::entry_t rd_entry,
  output logic            pop,
  output logic            out_valid,
  input  logic            out_ready,
  output logic [7:0]      out_ch,
  output logic            has_char,
  output logic            run_last,
  output logic            text_end
);
  import scs_pkg::*;

  entry_t     cur;
  logic       cur_valid;
  logic [1:0] idx;
  logic       last;
  logic       out_acc;

  assign last      = (idx == cur.last_idx);
  assign out_acc   = cur_valid && out_ready;
  assign pop       = rd_valid && (!cur_valid || (out_acc && last));
  assign out_valid = cur_valid;
  assign out_ch    = cur.bytes[idx];
  assign has_char  = !cur.bare;
  assign run_last  = last;
  assign text_end  = cur.is_end && last;

  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= rd_entry;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (pop) begin
      cur_valid <= 1'b1;
      idx       <= 2'd0;
    end else if (out_acc && last) begin
      cur_valid <= 1'b0;
      idx       <= 2'd0;
    end else if (out_acc) begin
      idx <= idx + 2'd1;
    end
  end

  `ASSERT_ALWAYS(a_idx_range, !cur_valid || idx <= cur.last_idx, "result index past group end")
  `ASSERT_ALWAYS(a_bare_is_end, !(cur_valid && cur.bare) || (cur.is_end && cur.last_idx == 2'd0), "bare marker outside end of text")

endmodule

/* rtl/core/source_comment_strip_normalize.sv */
// Each result group is written to a queue entry, then loaded into the output stage.
// Throughput: one input per cycle while each yields at most one result and the
// output is ready; a group of results holds the output port until its last result
// is taken, and the 2-entry queue absorbs bursts. Input with no result (comment
// bytes, folded spaces) is still accepted but pushes nothing. Reset (rst, synchronous):
// scan mode to normal, held space and text flags, queue and output stage cleared.
module source_comment_strip_normalize (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       func,
  input  logic [7:0] ch,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [7:0] out_ch,
  output logic       has_char,
  output logic       run_last,
  output logic       text_end
);
  import scs_pkg::*;

  push_t  wr;
  logic   q_full;
  logic   rd_valid;
  entry_t rd_entry;
  logic   pop;

  scs_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .func     (func),
    .ch       (ch),
    .q_full   (q_full),
    .wr       (wr)
  );

  scs_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .wr       (wr),
    .full     (q_full),
    .rd_valid (rd_valid),
    .rd_entry (rd_entry),
    .pop      (pop)
  );

  scs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .rd_valid  (rd_valid),
    .rd_entry  (rd_entry),
    .pop       (pop),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch    (out_ch),
    .has_char  (has_char),
    .run_last  (run_last),
    .text_end  (text_end)
  );

endmodule

/* verif/testbench.sv */
// Self-checking testbench for the comment strip normalizer.
`timescale 1ns / 100ps

module testbench;
  import scs_pkg::*;

  typedef struct packed {
    logic [7:0] ch;
    logic       has_char;
    logic       run_last;
    logic       text_end;
  } norm_byte_t;

  logic       clk = 1'b0;
  logic       rst = 1'b1;
  logic       in_valid = 1'b0;
  logic       in_ready;
  logic       func = FUNC_TEXT;
  logic [7:0] ch = 8'h00;
  logic       out_valid;
  logic       out_ready = 1'b0;
  logic [7:0] out_ch;
  logic       has_char;
  logic       run_last;
  logic       text_end;

  // Predicted normalizer state
  mode_t strip_mode = MODE_NORMAL;
  logic  space_held = 1'b0;
  logic  seen_text = 1'b0;

  norm_byte_t due_bytes[$];
  norm_byte_t item_bytes[$];

  int mismatches = 0;
  int bytes_sent = 0;
  int texts_closed = 0;
  int results_checked = 0;
  int input_stall_cycles = 0;
  int hold_off_request = 0;
  bit src_idle_on = 1'b1;
  bit snk_idle_on = 1'b1;

  source_comment_strip_normalize dut (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .func      (func),
    .ch        (ch),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_ch    (out_ch),
    .has_char  (has_char),
    .run_last  (run_last),
    .text_end  (text_end)
  );

  always #6 clk = ~clk;

  function automatic void emit_char(input logic [7:0] c);
    norm_byte_t r;
    r.ch       = c;
    r.has_char = 1'b1;
    r.run_last = 1'b0;
    r.text_end = 1'b0;
    item_bytes.push_back(r);
  endfunction

  // Fold whitespace, hold spaces until the next kept byte decides them.
  function automatic void keep_char(input logic [7:0] c);
    logic [7:0] k;
    logic       clause_mark;
    k = (c == CH_NL || c == CH_CR || c == CH_TAB) ? CH_SP : c;
    clause_mark = (k == CH_DOT) || (k == CH_COMMA) || (k == CH_QUEST) || (k == CH_SEMI);
    if (k == CH_SP) begin
      if (seen_text) space_held = 1'b1;
    end else begin
      if (space_held && !clause_mark) emit_char(CH_SP);
      space_held = 1'b0;
      emit_char(k);
      seen_text = 1'b1;
    end
  endfunction

  function automatic void normalize_item(input logic f, input logic [7:0] c);
    norm_byte_t marker;
    item_bytes.delete();
    if (f == FUNC_END) begin
      if (strip_mode == MODE_SLASH) keep_char(CH_SLASH);
      if (space_held) emit_char(CH_SP);
      if (item_bytes.size() == 0) begin
        marker = '0;
        item_bytes.push_back(marker);
      end
      item_bytes[item_bytes.size()-1].run_last = 1'b1;
      item_bytes[item_bytes.size()-1].text_end = 1'b1;
      strip_mode = MODE_NORMAL;
      space_held = 1'b0;
      seen_text  = 1'b0;
      texts_closed++;
    end else begin
      case (strip_mode)
        MODE_SLASH: begin
          if (c == CH_SLASH) strip_mode = MODE_LINE;
          else if (c == CH_STAR) strip_mode = MODE_BLOCK;
          else begin
            strip_mode = MODE_NORMAL;
            keep_char(CH_SLASH);
            keep_char(c);
          end
        end
        MODE_LINE: begin
          if (c == CH_NL) strip_mode = MODE_NORMAL;
        end
        MODE_BLOCK: begin
          if (c == CH_STAR) strip_mode = MODE_STAR;
        end
        MODE_STAR: begin
          if (c == CH_SLASH) strip_mode = MODE_NORMAL;
          else if (c != CH_STAR) strip_mode = MODE_BLOCK;
        end
        default: begin
          strip_mode = MODE_NORMAL;
          if (c == CH_SLASH) strip_mode = MODE_SLASH;
          else keep_char(c);
        end
      endcase
      if (item_bytes.size() > 0) item_bytes[item_bytes.size()-1].run_last = 1'b1;
    end
    foreach (item_bytes[i]) due_bytes.push_back(item_bytes[i]);
  endfunction

  // Offer one transaction; the prediction is made once acceptance is certain.
  task automatic send_byte(input logic f, input logic [7:0] c);
    int gap;
    gap = src_idle_on ? $urandom_range(0, 12) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    func     <= f;
    ch       <= c;
    forever begin
      @(negedge clk);
      if (in_ready) break;
      input_stall_cycles++;
    end
    normalize_item(f, c);
    bytes_sent++;
    @(posedge clk);
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(FUNC_TEXT, s[i]);
  endtask

  task automatic end_text();
    send_byte(FUNC_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_bytes.size() != 0) @(posedge clk);
  endtask

  // Result side: draw a wait per result, honor a requested long hold-off.
  initial begin : result_sink
    int wait_cycles;
    wait (!rst);
    forever begin
      if (hold_off_request > 0) begin
        wait_cycles = hold_off_request;
        hold_off_request = 0;
      end else begin
        wait_cycles = snk_idle_on ? $urandom_range(0, 12) : 0;
      end
      if (wait_cycles > 0) begin
        out_ready <= 1'b0;
        repeat (wait_cycles) @(posedge clk);
      end
      out_ready <= 1'b1;
      do @(negedge clk); while (!out_valid);
      @(posedge clk);
    end
  end

  always @(negedge clk) begin
    norm_byte_t want;
    if (!rst && out_valid && out_ready) begin
      if (due_bytes.size() == 0) begin
        $error("unexpected result: out_ch=%0h has_char=%0b", out_ch, has_char);
        mismatches++;
      end else begin
        want = due_bytes.pop_front();
        results_checked++;
        if (out_ch !== want.ch) begin
          $error("out_ch: expected %0h, got %0h", want.ch, out_ch);
          mismatches++;
        end
        if (has_char !== want.has_char) begin
          $error("has_char: expected %0b, got %0b", want.has_char, has_char);
          mismatches++;
        end
        if (run_last !== want.run_last) begin
          $error("run_last: expected %0b, got %0b", want.run_last, run_last);
          mismatches++;
        end
        if (text_end !== want.text_end) begin
          $error("text_end: expected %0b, got %0b", want.text_end, text_end);
          mismatches++;
        end
      end
    end
  end

  task automatic test_bare_end_marker();
    end_text();
    drain();
  endtask

  task automatic test_spaces_and_punct();
    send_text(" A ,b");
    send_byte(FUNC_TEXT, 8'hFF);
    send_byte(FUNC_TEXT, 8'h00);
    send_byte(FUNC_TEXT, CH_CR);
    send_byte(FUNC_TEXT, CH_TAB);
    end_text();
    drain();
  endtask

  task automatic test_comments();
    // A slash right after the opener does not close; a star run does.
    send_text("/x//c\n/*/**/q");
    end_text();
    drain();
  endtask

  task automatic test_flush_cases();
    send_text("k /");
    end_text();
    send_text("/*");
    end_text();
    drain();
  endtask

  task automatic send_random_token();
    int n;
    logic [7:0] c;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 5);
        repeat (n) send_byte(FUNC_TEXT, 8'($urandom_range(8'h61, 8'h7A)));
      end
      3: begin
        n = $urandom_range(1, 3);
        repeat (n) begin
          case ($urandom_range(0, 3))
            0: c = CH_SP;
            1: c = CH_TAB;
            2: c = CH_NL;
            default: c = CH_CR;
          endcase
          send_byte(FUNC_TEXT, c);
        end
      end
      4: begin
        case ($urandom_range(0, 3))
          0: c = CH_DOT;
          1: c = CH_COMMA;
          2: c = CH_QUEST;
          default: c = CH_SEMI;
        endcase
        send_byte(FUNC_TEXT, c);
      end
      5: begin
        send_text("//");
        n = $urandom_range(0, 4);
        repeat (n) send_byte(FUNC_TEXT, 8'($urandom_range(8'h20, 8'h7E)));
        send_byte(FUNC_TEXT, CH_NL);
      end
      6: begin
        send_text("/*");
        n = $urandom_range(0, 4);
        repeat (n) begin
          case ($urandom_range(0, 2))
            0: c = CH_STAR;
            1: c = CH_SLASH;
            default: c = 8'($urandom_range(0, 255));
          endcase
          send_byte(FUNC_TEXT, c);
        end
        // Leave some comments open to break the sequence.
        if ($urandom_range(0, 5) != 0) begin
          n = $urandom_range(1, 2);
          repeat (n) send_byte(FUNC_TEXT, CH_STAR);
          send_byte(FUNC_TEXT, CH_SLASH);
        end
      end
      7: begin
        send_byte(FUNC_TEXT, CH_SLASH);
        send_byte(FUNC_TEXT, $urandom_range(0, 1) ? CH_SP : 8'($urandom_range(8'h61, 8'h7A)));
      end
      8: begin
        n = $urandom_range(1, 2);
        repeat (n) send_byte(FUNC_TEXT, 8'($urandom_range(0, 255)));
      end
      default: begin
        if ($urandom_range(0, 2) == 0) end_text();
        else send_byte(FUNC_TEXT, 8'($urandom_range(0, 255)));
      end
    endcase
  endtask

  task automatic test_random_text();
    int stop_at;
    stop_at = bytes_sent + 120;
    while (bytes_sent < stop_at) begin
      if ($urandom_range(0, 15) == 0) src_idle_on = ~src_idle_on;
      if ($urandom_range(0, 15) == 0) snk_idle_on = ~snk_idle_on;
      send_random_token();
    end
    end_text();
    drain();
    src_idle_on = 1'b1;
    snk_idle_on = 1'b1;
  endtask

  // Hold the result side off while bytes keep coming, so the input stalls.
  task automatic test_output_backpressure();
    src_idle_on = 1'b0;
    hold_off_request = 80;
    send_text("ab cd;ef/gh ij,kl");
    end_text();
    drain();
    src_idle_on = 1'b1;
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    test_bare_end_marker();
    test_spaces_and_punct();
    test_comments();
    test_flush_cases();
    test_random_text();
    test_output_backpressure();
    repeat (10) @(posedge clk);
    $display("Covered %0d input transactions over %0d texts, %0d results checked,",
             bytes_sent, texts_closed, results_checked);
    $display("with %0d cycles of input stall from output hold-off.", input_stall_cycles);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #5ms;
    $display("Mismatches found");
    $finish;
  end

endmodule
